@@ rtl/fmm_pkg.sv @@
package fmm_pkg;

	localparam int MaxDim = 8;
	localparam int DimW = 4;
	localparam int CntW = 7;
	localparam logic [31:0] CanonNan = 32'h7FC00000;

	localparam logic [1:0] RegRowsA = 2'd0;
	localparam logic [1:0] RegInner = 2'd1;
	localparam logic [1:0] RegColsB = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [31:0] element;
	} in_item_t;

	typedef struct packed {
		logic [31:0] product;
		logic [2:0]  out_row;
		logic [2:0]  out_col;
		logic        final_res;
	} out_item_t;

	typedef struct packed {
		logic clear_acc;
		logic mac_go;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic mac_done;
	} dp_stat_t;

	typedef struct packed {
		logic        sign;
		logic [9:0]  exp;
		logic [27:0] mant;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
	} unp_t;

	function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] e,
		input logic [47:0] m);
		logic [47:0] mm;
		logic signed [11:0] ee;
		logic [5:0] lz;
		logic found;
		logic [23:0] keep;
		logic g, st;
		logic [24:0] r;
		logic [7:0] eo;
		logic [11:0] sh;
		logic [47:0] lost;
		mm = m;
		ee = e;
		lz = '0;
		found = 1'b0;
		keep = '0;
		g = 1'b0;
		st = 1'b0;
		r = '0;
		eo = '0;
		sh = '0;
		lost = '0;
		if (m == '0) begin
			return {sign, 31'd0};
		end
		for (int b = 47; b >= 0; b--) begin
			if (!found && m[b]) begin
				found = 1'b1;
				lz = 6'(47 - b);
			end
		end
		mm = m << lz;
		ee = e - 12'(lz);
		if (ee < 12'sd1) begin
			sh = 12'(12'sd1 - ee);
			if (sh > 12'd48) sh = 12'd48;
			lost = mm & ((48'd1 << sh) - 48'd1);
			mm = mm >> sh;
			ee = 12'sd0;
			st = (lost != '0);
		end
		keep = mm[47:24];
		g = mm[23];
		st = st | (mm[22:0] != '0);
		r = {1'b0, keep} + 25'((g && (st || keep[0])) ? 1 : 0);
		if (r[24]) begin
			r = r >> 1;
			ee = ee + 12'sd1;
		end
		if (ee == 12'sd0 && r[23]) ee = 12'sd1;
		if (ee >= 12'sd255) return {sign, 8'hFF, 23'd0};
		eo = ee[7:0];
		return {sign, eo, r[22:0]};
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic sa;
		logic [7:0] xa, xb;
		logic [23:0] ma, mb;
		logic [47:0] pm;
		logic nan, inf, zero;
		logic signed [11:0] e;
		sa = a[31] ^ b[31];
		xa = a[30:23];
		xb = b[30:23];
		ma = {xa != 0, a[22:0]};
		mb = {xb != 0, b[22:0]};
		nan = (xa == 8'hFF && a[22:0] != 0) || (xb == 8'hFF && b[22:0] != 0);
		inf = (xa == 8'hFF) || (xb == 8'hFF);
		zero = (a[30:0] == 0) || (b[30:0] == 0);
		e = 12'(xa == 0 ? 1 : xa) + 12'(xb == 0 ? 1 : xb) - 12'sd126;
		pm = ma * mb;
		if (nan || (inf && zero)) return CanonNan;
		if (inf) return {sa, 8'hFF, 23'd0};
		if (zero) return {sa, 31'd0};
		return round_pack(sa, e, pm);
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic [7:0] xa, xb, xl, xs;
		logic [47:0] la, lb, big, sm, res;
		logic sl, ss, rs;
		logic [7:0] d;
		logic an, bn, ai, bi;
		xa = a[30:23];
		xb = b[30:23];
		an = xa == 8'hFF && a[22:0] != 0;
		bn = xb == 8'hFF && b[22:0] != 0;
		ai = xa == 8'hFF && a[22:0] == 0;
		bi = xb == 8'hFF && b[22:0] == 0;
		la = {1'b0, xa != 0, a[22:0], 23'd0};
		lb = {1'b0, xb != 0, b[22:0], 23'd0};
		xa = (xa == 0) ? 8'd1 : xa;
		xb = (xb == 0) ? 8'd1 : xb;
		if (an || bn || (ai && bi && a[31] != b[31])) return CanonNan;
		if (ai) return a;
		if (bi) return b;
		if ({xa, la} >= {xb, lb}) begin
			big = la; sm = lb; xl = xa; xs = xb; sl = a[31]; ss = b[31];
		end else begin
			big = lb; sm = la; xl = xb; xs = xa; sl = b[31]; ss = a[31];
		end
		d = xl - xs;
		if (d > 8'd30) sm = {47'd0, sm != 0};
		else sm = (sm >> d) | {47'd0, (sm & ((48'd1 << d) - 48'd1)) != 0};
		if (sl == ss) begin
			res = big + sm;
			rs = sl;
		end else begin
			res = big - sm;
			rs = (res == 0) ? (a[31] & b[31]) : sl;
		end
		if (res == 0) return {rs, 31'd0};
		return round_pack(rs, 12'(xl) + 12'sd1, res);
	endfunction

	function automatic logic [3:0] eff_dim(input logic [DimW-1:0] v, input int maxd);
		if (v == '0) return 4'd1;
		if (32'(v) > maxd) return 4'(maxd);
		return v;
	endfunction

endpackage

@@ rtl/float_matrix_multiply.sv @@
// single precision matrix multiply P = A * B, A is rows_a x inner_len, B inner_len x cols_b
// load: pulse start with an item while busy is low; kind 0 appends to A, kind 1 to B,
// row-major; elements beyond a full matrix are dropped
// each accepted transaction holds busy for one cycle while the counts are checked,
// so the block cannot take a new element until that check is done
// once both matrices are full the block stays busy and computes every product element
// with one shared multiply then add unit (rounded product, rounded sum)
// for each element the controller issues k sram reads in turn, drains the last term
// through the multiply and add stages, then shows the result on the result ports
// results come on res_valid for one cycle each, row-major, final_res on the last;
// the receiver cannot stall and none is needed
// the user must write registers through cfg_we/cfg_index/cfg_data only while idle,
// which the block does not enforce; values of 0 act as 1 and above MAX_DIM as MAX_DIM
// reset clears counts and sets all dimensions to 8; the element stores are not cleared
module float_matrix_multiply #(
	parameter int MAX_DIM = fmm_pkg::MaxDim
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fmm_pkg::in_item_t   in_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data,
	output logic                res_valid,
	output fmm_pkg::out_item_t  res_item
);

	localparam int AW = $clog2(MAX_DIM*MAX_DIM);

	logic [3:0] rows_q, inner_q, cols_q, m, k, n;
	logic wr_a, wr_b, last;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	logic [2:0] row, col;
	logic [31:0] sum;
	fmm_pkg::dp_cmd_t cmd;
	fmm_pkg::dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd8;
			inner_q <= 4'd8;
			cols_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fmm_pkg::RegRowsA: rows_q <= cfg_data;
				fmm_pkg::RegInner: inner_q <= cfg_data;
				fmm_pkg::RegColsB: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign m = fmm_pkg::eff_dim(rows_q, MAX_DIM);
	assign k = fmm_pkg::eff_dim(inner_q, MAX_DIM);
	assign n = fmm_pkg::eff_dim(cols_q, MAX_DIM);

	fmm_ctrl #(.MaxDim(MAX_DIM)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .item(in_item), .m(m), .k(k), .n(n),
		.busy(busy), .wr_a(wr_a), .wr_b(wr_b), .waddr(waddr), .raddr_a(raddr_a),
		.raddr_b(raddr_b), .cmd(cmd), .stat(stat), .row(row), .col(col), .last(last)
	);

	fmm_datapath #(.MaxDim(MAX_DIM)) u_dp (
		.clk(clk), .arst_n(arst_n), .wr_a(wr_a), .wr_b(wr_b), .waddr(waddr),
		.wdata(in_item.element), .raddr_a(raddr_a), .raddr_b(raddr_b), .cmd(cmd),
		.stat(stat), .sum(sum)
	);

	assign res_valid = cmd.emit;
	assign res_item.product = (sum[30:23] == 8'hFF && sum[22:0] != 0) ? fmm_pkg::CanonNan : sum;
	assign res_item.out_row = row;
	assign res_item.out_col = col;
	assign res_item.final_res = last;

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy) else $error("result while idle");
	a_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept not followed by check");
	a_final_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.final_res) |=> !busy) else $error("busy after final");

endmodule

@@ rtl/fmm_ram.sv @@
module fmm_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/fmm_datapath.sv @@
module fmm_datapath #(
	parameter int MaxDim = fmm_pkg::MaxDim
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_a,
	input  logic                  wr_b,
	input  logic [$clog2(MaxDim*MaxDim)-1:0] waddr,
	input  logic [31:0]           wdata,
	input  logic [$clog2(MaxDim*MaxDim)-1:0] raddr_a,
	input  logic [$clog2(MaxDim*MaxDim)-1:0] raddr_b,
	input  fmm_pkg::dp_cmd_t      cmd,
	output fmm_pkg::dp_stat_t     stat,
	output logic [31:0]           sum
);

	logic [31:0] a_rd, b_rd, prod_s1, acc_q;
	logic        go_s1, go_s2;

	fmm_ram #(.Width(32), .Depth(MaxDim*MaxDim)) u_ram_a (
		.clk(clk), .we(wr_a), .waddr(waddr), .wdata(wdata), .raddr(raddr_a), .rdata(a_rd)
	);
	fmm_ram #(.Width(32), .Depth(MaxDim*MaxDim)) u_ram_b (
		.clk(clk), .we(wr_b), .waddr(waddr), .wdata(wdata), .raddr(raddr_b), .rdata(b_rd)
	);

	// read issued with mac_go, data in the next cycle, product registered, then add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
		end else begin
			go_s1 <= cmd.mac_go;
			go_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) prod_s1 <= fmm_pkg::fmul(a_rd, b_rd);
		if (cmd.clear_acc) acc_q <= 32'd0;
		else if (go_s2) acc_q <= fmm_pkg::fadd(acc_q, prod_s1);
	end

	assign stat.mac_done = go_s2;
	assign sum = acc_q;

endmodule

@@ rtl/fmm_ctrl.sv @@
module fmm_ctrl #(
	parameter int MaxDim = fmm_pkg::MaxDim
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  fmm_pkg::in_item_t     item,
	input  logic [3:0]            m,
	input  logic [3:0]            k,
	input  logic [3:0]            n,
	output logic                  busy,
	output logic                  wr_a,
	output logic                  wr_b,
	output logic [$clog2(MaxDim*MaxDim)-1:0] waddr,
	output logic [$clog2(MaxDim*MaxDim)-1:0] raddr_a,
	output logic [$clog2(MaxDim*MaxDim)-1:0] raddr_b,
	output fmm_pkg::dp_cmd_t      cmd,
	input  fmm_pkg::dp_stat_t     stat,
	output logic [2:0]            row,
	output logic [2:0]            col,
	output logic                  last
);

	localparam int AW = $clog2(MaxDim*MaxDim);

	typedef enum logic [1:0] {ST_LOAD, ST_CHECK, ST_MAC, ST_EMIT} state_t;

	state_t state_q;
	logic [fmm_pkg::CntW-1:0] cnt_a_q, cnt_b_q;
	logic [3:0] i_q, j_q, p_q;
	logic [7:0] size_a, size_b;
	logic take;

	assign size_a = 8'(m) * 8'(k);
	assign size_b = 8'(k) * 8'(n);
	assign take = start && (state_q == ST_LOAD);
	assign busy = (state_q != ST_LOAD);
	assign wr_a = take && !item.kind && (8'(cnt_a_q) < size_a);
	assign wr_b = take && item.kind && (8'(cnt_b_q) < size_b);
	assign waddr = item.kind ? cnt_b_q[AW-1:0] : cnt_a_q[AW-1:0];
	assign raddr_a = AW'(i_q) * AW'(k) + AW'(p_q);
	assign raddr_b = AW'(p_q) * AW'(n) + AW'(j_q);
	assign row = i_q[2:0];
	assign col = j_q[2:0];
	assign last = (i_q == m - 4'd1) && (j_q == n - 4'd1);

	always_comb begin
		cmd = '0;
		cmd.mac_go = (state_q == ST_MAC) && (p_q < k);
		cmd.emit = (state_q == ST_EMIT);
		cmd.clear_acc = (state_q == ST_CHECK) || (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q <= '0;
			j_q <= '0;
			p_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (wr_a) cnt_a_q <= cnt_a_q + 1'b1;
					if (wr_b) cnt_b_q <= cnt_b_q + 1'b1;
					if (take) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					i_q <= '0;
					j_q <= '0;
					p_q <= '0;
					if (8'(cnt_a_q) >= size_a && 8'(cnt_b_q) >= size_b) state_q <= ST_MAC;
					else state_q <= ST_LOAD;
				end
				ST_MAC: begin
					// p_q runs on to k + 1 so the last term can drain through multiply and add
					if (p_q <= k) p_q <= p_q + 4'd1;
					if (stat.mac_done && p_q == k + 4'd1) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					p_q <= '0;
					state_q <= ST_MAC;
					if (j_q == n - 4'd1) begin
						j_q <= '0;
						if (i_q == m - 4'd1) begin
							state_q <= ST_LOAD;
							cnt_a_q <= '0;
							cnt_b_q <= '0;
						end else i_q <= i_q + 4'd1;
					end else j_q <= j_q + 4'd1;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

@@ tb/tb_float_matrix_multiply.sv @@
`timescale 1ns / 100ps

module tb_float_matrix_multiply;

	localparam int WatchLimit = 20000;
	localparam int SettleCycles = 20;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  idx;
		logic [3:0]  val;
		logic        kind;
		logic [31:0] elem;
		bit          typed;
		logic [31:0] prod;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	fmm_pkg::in_item_t in_item = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;
	logic res_valid;
	fmm_pkg::out_item_t res_item;

	// own copy of the block state
	logic [3:0] dim_raw [3];
	logic [31:0] mat_a [64];
	logic [31:0] mat_b [64];
	int n_a, n_b;
	fmm_pkg::out_item_t pending_products[$];

	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_mults = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	stim_row_t directed[$];

	always #2 clk = ~clk;

	float_matrix_multiply DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.res_valid(res_valid), .res_item(res_item)
	);

	function automatic int dim_of(logic [3:0] v);
		if (v == 0) return 1;
		if (v > fmm_pkg::MaxDim) return fmm_pkg::MaxDim;
		return int'(v);
	endfunction

	function automatic logic [63:0] widen(logic [31:0] f);
		int e;
		logic [23:0] mm;
		if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'd0};
		if (f[30:0] == 0) return {f[31], 63'd0};
		if (f[30:23] == 0) begin
			mm = {1'b0, f[22:0]};
			e = -126;
			while (!mm[23]) begin
				mm = mm << 1;
				e--;
			end
		end else begin
			mm = {1'b1, f[22:0]};
			e = int'(f[30:23]) - 127;
		end
		return {f[31], 11'(e + 1023), mm[22:0], 29'd0};
	endfunction

	// round a double to single, nearest even, subnormals kept
	function automatic logic [31:0] narrow(logic [63:0] d);
		int be, sh;
		logic [63:0] m, kept, rem, half, mag;
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 0) ? fmm_pkg::CanonNan : {d[63], 8'hFF, 23'd0};
		if (d[62:52] == 0) return {d[63], 31'd0};
		m = {11'd0, 1'b1, d[51:0]};
		be = int'(d[62:52]) - 1023 + 127;
		sh = (be >= 1) ? 29 : 30 - be;
		if (sh > 60) return {d[63], 31'd0};
		kept = m >> sh;
		rem = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
		mag = (be >= 1) ? ((64'(be - 1) << 23) + kept) : kept;
		if (mag >= 64'h7F800000) return {d[63], 8'hFF, 23'd0};
		return {d[63], mag[30:0]};
	endfunction

	function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
		return narrow($realtobits($bitstoreal(widen(a)) * $bitstoreal(widen(b))));
	endfunction

	function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
		return narrow($realtobits($bitstoreal(widen(a)) + $bitstoreal(widen(b))));
	endfunction

	task automatic load_and_multiply(logic kind, logic [31:0] elem);
		int m, k, n;
		logic [31:0] sum;
		fmm_pkg::out_item_t r;
		m = dim_of(dim_raw[fmm_pkg::RegRowsA]);
		k = dim_of(dim_raw[fmm_pkg::RegInner]);
		n = dim_of(dim_raw[fmm_pkg::RegColsB]);
		if (!kind && n_a < m * k) mat_a[n_a++] = elem;
		if (kind && n_b < k * n) mat_b[n_b++] = elem;
		if (n_a < m * k || n_b < k * n) return;
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				sum = 32'h0;
				for (int p = 0; p < k; p++) sum = sp_add(sum, sp_mul(mat_a[i*k+p], mat_b[p*n+j]));
				if (sum[30:23] == 8'hFF && sum[22:0] != 0) sum = fmm_pkg::CanonNan;
				r.product = sum;
				r.out_row = 3'(i);
				r.out_col = 3'(j);
				r.final_res = (i == m - 1 && j == n - 1);
				pending_products.push_back(r);
			end
		end
		n_a = 0;
		n_b = 0;
		n_mults++;
	endtask

	// called at a rising edge; leaves start high so back-to-back items need no extra edge
	task automatic send_element(logic kind, logic [31:0] elem);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
				: $urandom_range(1, 8);
		end
		burst_left--;
		start <= 1'b1;
		in_item <= '{kind: kind, element: elem};
		do @(posedge clk); while (busy);
		n_items++;
		load_and_multiply(kind, elem);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_products.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_dims(logic [3:0] rows, logic [3:0] inner, logic [3:0] cols);
		logic [3:0] vals [3];
		vals = '{rows, inner, cols};
		wait_drained();
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			dim_raw[i] = vals[i];
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_element();
		logic [31:0] specials [8];
		specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00001, 32'h00000001, 32'h7F7FFFFF, 32'hFF7FFFFF};
		case ($urandom_range(0, 9))
			6: return $urandom;
			7: return specials[$urandom_range(0, 7)];
			8: return {1'($urandom), 8'd0, 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(110, 144)), 23'($urandom)};
		endcase
	endfunction

	function automatic logic [3:0] rand_dim(bit full_size, bit small_only);
		if (full_size) return 4'($urandom_range(8, 15));
		if (small_only) return 4'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			0: return 4'd0;
			1: return 4'($urandom_range(4, 7));
			default: return 4'($urandom_range(1, 3));
		endcase
	endfunction

	task automatic run_random_job();
		int na, nb;
		bit full_size, small_only;
		logic kind;
		// keep the item total near its target: large jobs only early on
		full_size = (n_items <= 72) && ($urandom_range(0, 14) == 0);
		small_only = (n_items > 120);
		write_dims(rand_dim(full_size, small_only), rand_dim(full_size, small_only),
			rand_dim(full_size, small_only));
		na = dim_of(dim_raw[fmm_pkg::RegRowsA]) * dim_of(dim_raw[fmm_pkg::RegInner]);
		nb = dim_of(dim_raw[fmm_pkg::RegInner]) * dim_of(dim_raw[fmm_pkg::RegColsB]);
		while (na > 0 || nb > 0) begin
			if (na == 0) kind = ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
			else if (nb == 0) kind = ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
			else kind = 1'($urandom);
			// an element of a full matrix is dropped, so it does not advance the load
			if (!kind && na > 0) na--;
			else if (kind && nb > 0) nb--;
			send_element(kind, rand_element());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			n_results++;
			if (pending_products.size() == 0) begin
				$error("unexpected result product=%h row=%0d col=%0d", res_item.product,
					res_item.out_row, res_item.out_col);
				errors++;
			end else begin
				fmm_pkg::out_item_t e;
				e = pending_products.pop_front();
				if (res_item.product !== e.product) begin
					$error("product expected %h actual %h", e.product, res_item.product);
					errors++;
				end
				if (res_item.out_row !== e.out_row) begin
					$error("out_row expected %0d actual %0d", e.out_row, res_item.out_row);
					errors++;
				end
				if (res_item.out_col !== e.out_col) begin
					$error("out_col expected %0d actual %0d", e.out_col, res_item.out_col);
					errors++;
				end
				if (res_item.final_res !== e.final_res) begin
					$error("final_res expected %0d actual %0d", e.final_res, res_item.final_res);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || res_valid || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("tb_float_matrix_multiply: FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		dim_raw = '{4'd8, 4'd8, 4'd8};
		n_a = 0;
		n_b = 0;
		// 1x1 products whose result is plain to see
		directed.push_back('{1, 0, 0, 0, 0, 0, 0});
		directed.push_back('{0, 0, 0, 0, 32'h40400000, 0, 0});
		directed.push_back('{0, 0, 0, 0, 32'h41200000, 0, 0});
		directed.push_back('{0, 0, 0, 1, 32'h40000000, 1, 32'h40C00000});
		directed.push_back('{0, 0, 0, 0, 32'h7F800000, 0, 0});
		directed.push_back('{0, 0, 0, 1, 32'h00000000, 1, fmm_pkg::CanonNan});
		directed.push_back('{0, 0, 0, 1, 32'h7F7FFFFF, 0, 0});
		directed.push_back('{0, 0, 0, 0, 32'h40000000, 1, 32'h7F800000});
		directed.push_back('{0, 0, 0, 0, 32'h00000001, 0, 0});
		directed.push_back('{0, 0, 0, 1, 32'h3F000000, 1, 32'h00000000});
		directed.push_back('{0, 0, 0, 0, 32'h80000000, 0, 0});
		directed.push_back('{0, 0, 0, 1, 32'h3F800000, 1, 32'h00000000});
		directed.push_back('{0, 0, 0, 0, 32'hFFFFFFFF, 0, 0});
		directed.push_back('{0, 0, 0, 1, 32'h7F7FFFFF, 1, fmm_pkg::CanonNan});
		// 8x1 times 1x1 with register values clamped from both sides
		directed.push_back('{1, 0, 4'd15, 0, 0, 0, 0});
		for (int i = 0; i < 8; i++)
			directed.push_back('{0, 0, 0, 0, {1'(i), 8'(120 + i), 23'($urandom)}, 0, 0});
		directed.push_back('{0, 0, 0, 1, 32'hC0490FDB, 0, 0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r]) begin
			row = directed[r];
			if (row.is_cfg) begin
				write_dims(row.val == 0 ? 4'd1 : row.val, 4'd0, 4'd0);
			end else begin
				send_element(row.kind, row.elem);
				if (row.typed) pending_products[$].product = row.prod;
			end
		end

		while (n_items < 200) run_random_job();
		wait_drained();

		$display("covered %0d items, %0d matrix products, %0d product elements", n_items,
			n_mults, n_results);
		$display("dimensions from 1x1x1 to 8x8x8 incl. clamped register values, specials and noise");
		if (errors == 0) $display("tb_float_matrix_multiply: PASS");
		else $display("tb_float_matrix_multiply: FAIL");
		$finish;
	end

endmodule
